>>> design/swb_pkg.sv
// ----------------------------------------------------------------------------
// swb_pkg
// Shared types and constants of the swap block allocator: request and response
// payloads, request and status codes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package swb_pkg;

  localparam int NUM_BLOCKS_DEF = 256;

  // Request codes.
  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Response status codes.
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_FAIL    = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] owner_id;
    logic [19:0] page_number;
    logic [7:0]  slot_in;
  } swb_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot_out;
    logic [8:0] free_left;
  } swb_rsp_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_CHK,
    S_CLEAR,
    S_POST
  } swb_state_t;

  typedef struct packed {
    logic       load;         // capture the accepted request
    logic       scan_clr;     // restart the table pointer at block zero
    logic       scan_run;     // read one block per cycle and advance
    logic       sweep;        // write an empty entry at the pointer and advance
    logic       free_rd;      // read the block named by the request
    logic       commit_scan;  // take or release the block found by the scan
    logic       commit_free;  // release the block named by the request
    logic       reset_total;  // free count back to the table size
    logic       set_res;      // record res_code with slot zero
    logic [1:0] res_code;
    logic       out_load;     // move the result into the output register
  } swb_cmd_t;

  typedef struct packed {
    logic [1:0] in_type;
    logic       hit;
    logic       chk_last;
    logic       scan_last;
    logic       total_zero;
    logic       free_ok;
  } swb_sts_t;

endpackage

>>> design/swap_block_allocator.sv
// ----------------------------------------------------------------------------
// swap_block_allocator
// First-fit allocator over a table of swap blocks with owner and page tags.
// ----------------------------------------------------------------------------
// One request is worked at a time; a finished response waits in an output
// register, so the next request is taken while it is still pending. The table
// sits in a single-port-read, single-port-write memory and is scanned one block
// per cycle from block zero up to the first free or matching block; an
// allocate with no free block answers without a scan. Free by index reads and
// checks the named block; a clear request writes one block per cycle. After
// reset a clearing pass runs with req_ready low.
module swap_block_allocator #(
  parameter int NUM_BLOCKS = swb_pkg::NUM_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  swb_pkg::swb_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output swb_pkg::swb_rsp_t rsp
);

  swb_pkg::swb_cmd_t cmd;
  swb_pkg::swb_sts_t sts;

  swb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swb_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

  // A response that is not done never carries a block index.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != swb_pkg::STAT_DONE) |-> rsp.slot_out == 8'd0)
    else $error("nonzero slot on a failed or ignored response");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == swb_pkg::STAT_DONE) ||
                  (rsp.status == swb_pkg::STAT_FAIL) ||
                  (rsp.status == swb_pkg::STAT_IGNORED))
    else $error("undefined status code");

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request accepted while one is in work");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.sweep && (cmd.commit_scan || cmd.commit_free)) &&
    !(cmd.commit_scan && cmd.commit_free))
    else $error("two writers on the block table");

endmodule

>>> design/swb_datapath.sv
// ----------------------------------------------------------------------------
// swb_datapath
// Block table memory (used mark, owner, page), table pointer, free count,
// result staging and the output register.
// ----------------------------------------------------------------------------
module swb_datapath #(
  parameter int NUM_BLOCKS = swb_pkg::NUM_BLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  swb_pkg::swb_req_t req,
  input  swb_pkg::swb_cmd_t cmd,
  output swb_pkg::swb_sts_t sts,
  output swb_pkg::swb_rsp_t rsp
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam logic [IW-1:0] LAST = IW'(NUM_BLOCKS - 1);

  typedef struct packed {
    logic        used;
    logic [15:0] owner;
    logic [19:0] page;
  } entry_t;

  entry_t mem [NUM_BLOCKS];

  swb_pkg::swb_req_t cur;
  logic [IW-1:0]     scan_idx;
  logic [IW-1:0]     chk_idx;
  logic              chk_vld;
  entry_t            rd_data;
  logic [CW-1:0]     free_total;
  logic [1:0]        res_status;
  logic [IW-1:0]     res_slot;
  swb_pkg::swb_rsp_t rsp_q;

  logic [IW-1:0] slot_idx;
  logic          slot_in_range;
  logic          lookup_mode;
  logic          match;
  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  assign slot_idx      = IW'(cur.slot_in);
  assign slot_in_range = (32'(cur.slot_in) < 32'(NUM_BLOCKS));
  assign lookup_mode   = (cur.req_type == swb_pkg::REQ_LOOKUP);
  assign rd_addr       = cmd.free_rd ? slot_idx : scan_idx;
  assign rd_en         = cmd.scan_run | cmd.free_rd;

  always_comb begin
    if (lookup_mode) begin
      match = rd_data.used && (rd_data.owner == cur.owner_id) &&
              (rd_data.page == cur.page_number);
    end else begin
      match = !rd_data.used;
    end
  end

  always_comb begin
    sts.in_type    = req.req_type;
    sts.hit        = chk_vld && match;
    sts.chk_last   = chk_vld && (chk_idx == LAST);
    sts.scan_last  = (scan_idx == LAST);
    sts.total_zero = (free_total == '0);
    sts.free_ok    = slot_in_range && rd_data.used;
  end

  // Single write port: clearing sweep, scan commit or free commit.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = scan_idx;
    wr_data = '0;
    if (cmd.sweep) begin
      wr_en = 1'b1;
    end else if (cmd.commit_scan) begin
      wr_en   = 1'b1;
      wr_addr = chk_idx;
      if (!lookup_mode) begin
        wr_data = '{used: 1'b1, owner: cur.owner_id, page: cur.page_number};
      end
    end else if (cmd.commit_free) begin
      wr_en   = 1'b1;
      wr_addr = slot_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
    if (cmd.scan_run) begin
      chk_idx <= scan_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      chk_vld  <= 1'b0;
    end else begin
      if (cmd.scan_clr) begin
        scan_idx <= '0;
        chk_vld  <= 1'b0;
      end else begin
        if ((cmd.scan_run || cmd.sweep) && (scan_idx != LAST)) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (cmd.scan_run) begin
          chk_vld <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_total <= CW'(NUM_BLOCKS);
    end else if (cmd.reset_total) begin
      free_total <= CW'(NUM_BLOCKS);
    end else if (cmd.commit_scan) begin
      if (lookup_mode) begin
        free_total <= free_total + 1'b1;
      end else begin
        free_total <= free_total - 1'b1;
      end
    end else if (cmd.commit_free) begin
      free_total <= free_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_scan) begin
      res_status <= swb_pkg::STAT_DONE;
      res_slot   <= chk_idx;
    end else if (cmd.commit_free) begin
      res_status <= swb_pkg::STAT_DONE;
      res_slot   <= '0;
    end else if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_slot   <= '0;
    end
    if (cmd.out_load) begin
      rsp_q.status    <= res_status;
      rsp_q.slot_out  <= 8'(res_slot);
      rsp_q.free_left <= 9'(free_total);
    end
  end

  assign rsp = rsp_q;

endmodule

>>> design/swb_ctrl.sv
// ----------------------------------------------------------------------------
// swb_ctrl
// Request sequencer: clearing pass, table scan, free by index, clear request
// and hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module swb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  swb_pkg::swb_sts_t sts,
  output swb_pkg::swb_cmd_t cmd
);

  swb_pkg::swb_state_t state;
  swb_pkg::swb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swb_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      swb_pkg::S_INIT: begin
        if (sts.scan_last) state_next = swb_pkg::S_IDLE;
      end
      swb_pkg::S_IDLE: begin
        if (req_valid) begin
          case (sts.in_type)
            swb_pkg::REQ_ALLOC: begin
              state_next = sts.total_zero ? swb_pkg::S_POST : swb_pkg::S_SCAN;
            end
            swb_pkg::REQ_FREE:   state_next = swb_pkg::S_FREE_RD;
            swb_pkg::REQ_LOOKUP: state_next = swb_pkg::S_SCAN;
            default:             state_next = swb_pkg::S_CLEAR;
          endcase
        end
      end
      swb_pkg::S_SCAN: begin
        if (sts.hit || sts.chk_last) state_next = swb_pkg::S_POST;
      end
      swb_pkg::S_FREE_RD:  state_next = swb_pkg::S_FREE_CHK;
      swb_pkg::S_FREE_CHK: state_next = swb_pkg::S_POST;
      swb_pkg::S_CLEAR: begin
        if (sts.scan_last) state_next = swb_pkg::S_POST;
      end
      swb_pkg::S_POST: begin
        if (!rsp_valid || rsp_ready) state_next = swb_pkg::S_IDLE;
      end
      default: state_next = swb_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      swb_pkg::S_INIT: begin
        cmd.sweep = 1'b1;
        cmd.reset_total = sts.scan_last;
      end
      swb_pkg::S_IDLE: begin
        req_ready    = 1'b1;
        cmd.load     = req_valid;
        cmd.scan_clr = req_valid;
        if (req_valid && (sts.in_type == swb_pkg::REQ_ALLOC) && sts.total_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = swb_pkg::STAT_FAIL;
        end
      end
      swb_pkg::S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.hit) begin
          cmd.commit_scan = 1'b1;
        end else if (sts.chk_last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = swb_pkg::STAT_FAIL;
        end
      end
      swb_pkg::S_FREE_RD: begin
        cmd.free_rd = 1'b1;
      end
      swb_pkg::S_FREE_CHK: begin
        if (sts.free_ok) begin
          cmd.commit_free = 1'b1;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_code = swb_pkg::STAT_IGNORED;
        end
      end
      swb_pkg::S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.scan_last) begin
          cmd.reset_total = 1'b1;
          cmd.set_res     = 1'b1;
          cmd.res_code    = swb_pkg::STAT_DONE;
        end
      end
      swb_pkg::S_POST: begin
        cmd.out_load = !rsp_valid || rsp_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
